[sv/jcpt_pkg.sv]
// Shared types, widths and constants for the jitter-compensated periodic timer bank.
// Depends on nothing; every other file but jcpt_ram imports it.
package jcpt_pkg;

    // bank geometry
    localparam int NUM_TIMERS   = 8;
    localparam int WARMUP_FIRES = 64;
    localparam int TIMER_AW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // field widths
    localparam int IDX_W    = 3;
    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 40;
    localparam int CNT_W    = 7;
    localparam int AVG_W    = 12;
    localparam int OFF_W    = 10;
    localparam int TMR_W    = PERIOD_W + TIME_W;

    // constants
    localparam logic [TIME_W-1:0]   TIME_MAX     = '1;
    localparam logic [PERIOD_W-1:0] ONE_MS       = PERIOD_W'(1000000);
    localparam int                  SAMPLE_LIMIT = 2000;
    localparam int                  OFFSET_LIMIT = 500;
    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
    localparam logic [CNT_W-1:0]    WARMUP_CNT   = CNT_W'(WARMUP_FIRES);

    typedef enum logic {
        MODE_ARM  = 1'b0,
        MODE_FIRE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_AVG,
        ST_NOM,
        ST_DL,
        ST_OUT
    } state_t;

    // sequencer strobes to the datapath
    typedef struct packed {
        logic evt_ready;
        logic stage_read;
        logic stage_avg;
        logic stage_nom;
        logic stage_dl;
        logic commit;
    } ctrl_t;

    // command to the shared jitter filter
    typedef struct packed {
        logic                    clr;
        logic                    upd;
        logic                    comp_en;
        logic signed [AVG_W-1:0] jit;
    } filter_cmd_t;

    // time sum saturating at the top of the 63-bit range
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

[sv/jcpt_ifs.sv]
// Valid/ready channel interfaces: timer events in, timer results out, config write.
// Depends on jcpt_pkg for field widths.
interface jcpt_evt_if;
    import jcpt_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [IDX_W-1:0]    timer_index;
    logic [TIME_W-1:0]   now_ns;
    logic [PERIOD_W-1:0] period_ns;

    modport source (output valid, mode, timer_index, now_ns, period_ns, input ready);
    modport sink   (input valid, mode, timer_index, now_ns, period_ns, output ready);
endinterface

interface jcpt_res_if;
    import jcpt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       next_deadline_ns;
    logic                    sample_taken;
    logic                    comp_applied;
    logic signed [AVG_W-1:0] average_jitter_ns;
    logic signed [OFF_W-1:0] offset_ns;

    modport source (output valid, next_deadline_ns, sample_taken, comp_applied,
                    average_jitter_ns, offset_ns, input ready);
    modport sink   (input valid, next_deadline_ns, sample_taken, comp_applied,
                    average_jitter_ns, offset_ns, output ready);
endinterface

interface jcpt_cfg_if;
    logic valid;
    logic ready;
    logic comp_enable;

    modport source (output valid, comp_enable, input ready);
    modport sink   (input valid, comp_enable, output ready);
endinterface

[sv/jcpt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module jcpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/jcpt_filter.sv]
// Shared jitter filter: EWMA of jitter samples and the clamped compensation offset.
// Depends on jcpt_pkg.
module jcpt_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jcpt_pkg::filter_cmd_t             cmd,
    output logic signed [jcpt_pkg::AVG_W-1:0] avg,
    output logic signed [jcpt_pkg::OFF_W-1:0] off
);
    import jcpt_pkg::*;

    localparam int ACC_W = AVG_W + 5;
    localparam logic signed [AVG_W-1:0] OFF_HI = AVG_W'(OFFSET_LIMIT);
    localparam logic signed [AVG_W-1:0] OFF_LO = -AVG_W'(OFFSET_LIMIT);

    logic signed [AVG_W-1:0] avg_reg, avg_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic signed [ACC_W-1:0] avg_ext, jit_ext, acc;
    logic signed [AVG_W-1:0] avg_upd;
    logic signed [OFF_W-1:0] off_clamp;

    // 15*old + sample, then floor divide by 16
    always_comb
    begin
        avg_ext = ACC_W'(avg_reg);
        jit_ext = ACC_W'(cmd.jit);
        acc     = (avg_ext <<< 4) - avg_ext + jit_ext;
        avg_upd = acc[AVG_W+3:4];
        if (avg_upd > OFF_HI)
        begin
            off_clamp = OFF_W'(OFF_HI);
        end
        else if (avg_upd < OFF_LO)
        begin
            off_clamp = OFF_W'(OFF_LO);
        end
        else
        begin
            off_clamp = avg_upd[OFF_W-1:0];
        end
    end

    // next state of the shared filter
    always_comb
    begin
        avg_next = avg_reg;
        off_next = off_reg;
        if (cmd.clr)
        begin
            avg_next = '0;
            off_next = '0;
        end
        else if (cmd.upd)
        begin
            avg_next = avg_upd;
            if (cmd.comp_en)
            begin
                off_next = off_clamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            avg_reg <= avg_next;
            off_reg <= off_next;
        end
    end

    assign avg = avg_reg;
    assign off = off_reg;

endmodule

[sv/jcpt_ctrl.sv]
// Event sequencer: steps one event through read, filter, nominal, deadline and commit.
// Depends on jcpt_pkg.
module jcpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            evt_valid,
    input  logic            out_free,
    output jcpt_pkg::ctrl_t ctl
);
    import jcpt_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (evt_valid) state_next = ST_READ;
            ST_READ: state_next = ST_AVG;
            ST_AVG:  state_next = ST_NOM;
            ST_NOM:  state_next = ST_DL;
            ST_DL:   state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: ctl.evt_ready  = 1'b1;
            ST_READ: ctl.stage_read = 1'b1;
            ST_AVG:  ctl.stage_avg  = 1'b1;
            ST_NOM:  ctl.stage_nom  = 1'b1;
            ST_DL:   ctl.stage_dl   = 1'b1;
            ST_OUT:  ctl.commit     = out_free;
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/jitter_compensated_periodic_timer_top.sv]
// Top level of the jitter-compensated periodic timer bank.
// Depends on jcpt_pkg, jcpt_ifs, jcpt_ram, jcpt_filter and jcpt_ctrl.
//
// One event (arm or fire) is taken at a time. The sequencer steps an accepted
// beat through the timer memory read, then one stage each for the filter
// update, the nominal-time catch-up, the offset subtraction and the final
// deadline check with commit; the next event is accepted only once the
// sequencer has returned to idle, and the commit waits while the output side
// is stalled. A finished result sits in the output register; a new event is
// taken while it waits, and only the commit of the following event waits for
// it to drain. Period and nominal time live in one memory, fire counts in
// another with a per-timer valid bit cleared by reset. comp_enable resets to
// 1 and may be written whenever no event is in flight.
module jitter_compensated_periodic_timer_top (
    input logic      clk,
    input logic      rst_n,
    jcpt_evt_if.sink evt,
    jcpt_res_if.source res,
    jcpt_cfg_if.sink cfg
);
    import jcpt_pkg::*;

    localparam logic signed [TIME_W:0] SLIM = (TIME_W+1)'(SAMPLE_LIMIT);

    ctrl_t       ctl;
    filter_cmd_t fcmd;
    logic        acc_evt;
    logic        out_free;

    logic                    comp_en_reg;
    logic [NUM_TIMERS-1:0]   cnt_vld_reg;

    // captured event
    logic                mode_reg;
    logic                in_bank_reg;
    logic [TIMER_AW-1:0] addr_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [PERIOD_W-1:0] ivl_reg;

    // memory ports
    logic [TMR_W-1:0]    tmr_rd, tmr_wr;
    logic [CNT_W-1:0]    cnt_rd, cnt_wr;
    logic                mem_we;

    // read stage
    logic [PERIOD_W-1:0]     per_rd;
    logic [TIME_W-1:0]       nom_rd;
    logic [CNT_W-1:0]        cnt_old;
    logic signed [TIME_W:0]  diff;
    logic                    in_win;

    logic [PERIOD_W-1:0]     per_reg;
    logic [TIME_W-1:0]       nom1_reg;
    logic [CNT_W-1:0]        cnt_old_reg;
    logic                    sample_reg;
    logic signed [AVG_W-1:0] jit_reg;

    // later stages
    logic [TIME_W-1:0]       nom2_reg, fall_reg, nom_new_reg, dl_reg, dl_next;
    logic [CNT_W-1:0]        cnt_new_reg;
    logic                    applied_reg;
    logic signed [AVG_W-1:0] avg;
    logic signed [OFF_W-1:0] off;
    logic [OFF_W-1:0]        off_abs;
    logic [TIME_W-1:0]       off_t;
    logic [TIME_W-1:0]       final_dl;
    logic [PERIOD_W-1:0]     per_arm;

    // output register
    logic                    res_valid_reg;
    logic [TIME_W-1:0]       res_dl_reg;
    logic                    res_sample_reg;
    logic                    res_applied_reg;
    logic signed [AVG_W-1:0] res_avg_reg;
    logic signed [OFF_W-1:0] res_off_reg;

    assign acc_evt  = evt.valid && ctl.evt_ready;
    assign out_free = !res_valid_reg || res.ready;
    assign evt.ready = ctl.evt_ready;
    assign cfg.ready = 1'b1;

    jcpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            comp_en_reg <= cfg.comp_enable;
        end
    end

    // capture the event beat
    always_ff @(posedge clk)
    begin
        if (acc_evt)
        begin
            mode_reg    <= evt.mode;
            in_bank_reg <= (int'(evt.timer_index) < NUM_TIMERS);
            addr_reg    <= TIMER_AW'(evt.timer_index);
            now_reg     <= evt.now_ns;
            ivl_reg     <= evt.period_ns;
        end
    end

    // period and nominal time of each timer
    jcpt_ram #(
        .WIDTH (TMR_W),
        .DEPTH (NUM_TIMERS)
    ) u_tmr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (tmr_wr),
        .re    (acc_evt),
        .raddr (TIMER_AW'(evt.timer_index)),
        .rdata (tmr_rd)
    );

    // fire count of each timer
    jcpt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (cnt_wr),
        .re    (acc_evt),
        .raddr (TIMER_AW'(evt.timer_index)),
        .rdata (cnt_rd)
    );

    // read stage: jitter measurement and first nominal advance
    always_comb
    begin
        per_rd  = tmr_rd[TMR_W-1:TIME_W];
        nom_rd  = tmr_rd[TIME_W-1:0];
        cnt_old = cnt_vld_reg[addr_reg] ? cnt_rd : '0;
        diff    = $signed({1'b0, now_reg}) - $signed({1'b0, nom_rd});
        in_win  = (diff >= -SLIM) && (diff <= SLIM);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.stage_read)
        begin
            per_reg     <= per_rd;
            nom1_reg    <= sat_add(nom_rd, TIME_W'(per_rd));
            cnt_old_reg <= cnt_old;
            sample_reg  <= in_bank_reg && (mode_reg == MODE_FIRE)
                           && (cnt_old != '0) && in_win;
            jit_reg     <= diff[AVG_W-1:0];
        end
    end

    // filter stage
    always_comb
    begin
        fcmd.clr     = ctl.stage_avg && in_bank_reg && (mode_reg == MODE_ARM);
        fcmd.upd     = ctl.stage_avg && sample_reg;
        fcmd.comp_en = comp_en_reg;
        fcmd.jit     = jit_reg;
    end

    jcpt_filter u_filter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fcmd),
        .avg   (avg),
        .off   (off)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.stage_avg)
        begin
            nom2_reg    <= sat_add(nom1_reg, TIME_W'(per_reg));
            fall_reg    <= sat_add(now_reg, TIME_W'(per_reg));
            cnt_new_reg <= (cnt_old_reg == CNT_MAX) ? cnt_old_reg : cnt_old_reg + 1'b1;
        end
    end

    // nominal catch-up stage
    always_ff @(posedge clk)
    begin
        if (ctl.stage_nom)
        begin
            nom_new_reg <= (now_reg > nom2_reg) ? fall_reg : nom1_reg;
            applied_reg <= comp_en_reg && (cnt_new_reg > WARMUP_CNT);
        end
    end

    // offset stage: subtract the offset, floor at zero, saturate at the top
    always_comb
    begin
        off_abs = off[OFF_W-1] ? (~off + 1'b1) : off;
        off_t   = TIME_W'(off_abs);
        dl_next = nom_new_reg;
        if (applied_reg)
        begin
            if (!off[OFF_W-1])
            begin
                dl_next = (nom_new_reg >= off_t) ? nom_new_reg - off_t : '0;
            end
            else
            begin
                dl_next = sat_add(nom_new_reg, off_t);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.stage_dl)
        begin
            dl_reg <= dl_next;
        end
    end

    // commit: late fallback, write-back, result
    assign final_dl = (dl_reg < now_reg) ? fall_reg : dl_reg;
    assign per_arm  = (ivl_reg == '0) ? ONE_MS : ivl_reg;
    assign mem_we   = ctl.commit && in_bank_reg;

    always_comb
    begin
        if (mode_reg == MODE_ARM)
        begin
            tmr_wr = {per_arm, now_reg};
            cnt_wr = '0;
        end
        else
        begin
            tmr_wr = {per_reg, nom_new_reg};
            cnt_wr = cnt_new_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            cnt_vld_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            res_avg_reg <= avg;
            res_off_reg <= off;
            if (!in_bank_reg)
            begin
                res_dl_reg      <= '0;
                res_sample_reg  <= 1'b0;
                res_applied_reg <= 1'b0;
            end
            else if (mode_reg == MODE_ARM)
            begin
                res_dl_reg      <= now_reg;
                res_sample_reg  <= 1'b0;
                res_applied_reg <= 1'b0;
            end
            else
            begin
                res_dl_reg      <= final_dl;
                res_sample_reg  <= sample_reg;
                res_applied_reg <= applied_reg;
            end
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.next_deadline_ns  = res_dl_reg;
    assign res.sample_taken      = res_sample_reg;
    assign res.comp_applied      = res_applied_reg;
    assign res.average_jitter_ns = res_avg_reg;
    assign res.offset_ns         = res_off_reg;

endmodule

[sv/jcpt_checker.sv]
// Port-level checks for the timer bank, bound to the top level.
// Depends on jcpt_pkg and jitter_compensated_periodic_timer_top.
module jcpt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              evt_valid,
    input logic                              evt_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [jcpt_pkg::TIME_W-1:0]       res_dl,
    input logic signed [jcpt_pkg::AVG_W-1:0] res_avg,
    input logic signed [jcpt_pkg::OFF_W-1:0] res_off
);
    import jcpt_pkg::*;

    localparam logic signed [OFF_W-1:0] OFF_HI = OFF_W'(OFFSET_LIMIT);
    localparam logic signed [AVG_W-1:0] AVG_HI = AVG_W'(SAMPLE_LIMIT);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_dl))
        else $error("result beat changed while stalled");

    // one event in flight: no second event right after an accepted one
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !(evt_valid && evt_ready))
        else $error("second event accepted while one is in flight");

    // offset stays inside the clamp
    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_off <= OFF_HI) && (res_off >= -OFF_HI))
        else $error("offset outside clamp range");

    // average stays inside the sample window
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_avg <= AVG_HI) && (res_avg >= -AVG_HI))
        else $error("average outside sample window");

endmodule

bind jitter_compensated_periodic_timer_top jcpt_checker u_jcpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_dl    (res.next_deadline_ns),
    .res_avg   (res.average_jitter_ns),
    .res_off   (res.offset_ns)
);
